/* rtl/core/msl_pkg.sv */
package msl_pkg;

   localparam int NUM_SLOTS   = 8;
   localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int DEG_SPAN    = 180;
   localparam int LIMIT_QUANT = 4;
   localparam int STEP_RESET  = 2000;

   localparam logic [11:0] BASE_MIN_RESET = 12'd544;
   localparam logic [11:0] BASE_MAX_RESET = 12'd2400;
   localparam logic [11:0] DEFAULT_RESET  = 12'd1500;

   localparam int NUM_W  = 25;
   localparam int DEN_W  = 13;
   localparam int QUO_W  = NUM_W - 1;
   localparam int CNT_W  = $clog2(QUO_W);
   localparam int MULA_W = 17;
   localparam int PROD_W = MULA_W + DEN_W;

   // divide by 180 as a shift by 2 and a multiply by 2^24 / 45, rounded up
   localparam int          RECIP_SHIFT = 24;
   localparam logic [18:0] DEG_RECIP   = 19'd372828;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CSR_BASE_MIN = 2'd0;
   localparam logic [1:0] CSR_BASE_MAX = 2'd1;
   localparam logic [1:0] CSR_DEFAULT  = 2'd2;

   localparam logic KIND_PULSE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [2:0] {
      OP_WRITE  = 3'd0,
      OP_STEP   = 3'd1,
      OP_ATTACH = 3'd2,
      OP_DETACH = 3'd3,
      OP_TICK   = 3'd4,
      OP_READ   = 3'd5
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [2:0]         slot;
      logic signed [15:0] value;
      logic [14:0]        step_size;
      logic [11:0]        min_us;
      logic [11:0]        max_us;
   } cmd_type;

   typedef struct packed {
      logic               kind;
      logic [2:0]         out_slot;
      logic signed [15:0] pulse_us;
      logic signed [15:0] angle_deg;
      logic               is_attached;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [11:0] base_min;
      logic [11:0] base_max;
      logic [11:0] default_pulse;
   } cfg_type;

   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic signed [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [NUM_W-1:0] quot;
   } div_rsp_type;

   // limit snapped to 4 us steps from the base, truncating toward zero
   function automatic logic [11:0] quantize(input logic [11:0] base, input logic [11:0] req);
      logic signed [12:0] d;
      logic [11:0]        mag;
      logic [11:0]        qm;
      logic [12:0]        res;
      d   = $signed({1'b0, base}) - $signed({1'b0, req});
      mag = d[12] ? 12'(-d) : d[11:0];
      qm  = mag - (mag % 12'(LIMIT_QUANT));
      res = d[12] ? ({1'b0, base} + {1'b0, qm}) : ({1'b0, base} - {1'b0, qm});
      return res[11:0];
   endfunction

endpackage

/* rtl/core/msl_cmd_queue.sv */
module msl_cmd_queue import msl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [2:0]        req_operation,
   input  logic [2:0]        req_slot,
   input  logic signed [15:0] req_value,
   input  logic [14:0]       req_step_size,
   input  logic [11:0]       req_min_us,
   input  logic [11:0]       req_max_us,
   output logic              cmd_valid,
   output cmd_type           cmd,
   input  logic              cmd_pop
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                known, keep, wr, rd;
   cmd_type             entry;

   always_comb begin
      case (req_operation)
         OP_WRITE, OP_STEP, OP_ATTACH, OP_DETACH, OP_TICK, OP_READ: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign keep = known && ((req_operation == OP_TICK) || ({4'd0, req_slot} < 7'(NUM_SLOTS)));
   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign wr   = push && !full && keep;
   assign cmd_valid = (count_ff != '0);
   assign rd   = cmd_pop && cmd_valid;
   assign cmd  = mem_ff[rd_ptr_ff];

   always_comb begin
      entry.op        = op_type'(req_operation);
      entry.slot      = req_slot;
      entry.value     = req_value;
      entry.step_size = req_step_size;
      entry.min_us    = req_min_us;
      entry.max_us    = req_max_us;
      count_in = count_ff + QCNT_W'(wr) - QCNT_W'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* rtl/core/msl_rsp_queue.sv */
module msl_rsp_queue import msl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    rsp_push,
   input  rsp_type rsp_in,
   output logic    rsp_full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_out
);

   rsp_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                wr, rd;

   assign rsp_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign wr       = rsp_push && !rsp_full;
   assign rd       = pop && !empty;
   assign rsp_out  = mem_ff[rd_ptr_ff];
   assign count_in = count_ff + QCNT_W'(wr) - QCNT_W'(rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

/* rtl/core/msl_div.sv */
module msl_div import msl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic               busy_ff, done_ff, neg_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DEN_W-2:0]   rem_ff, den_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in, num_mag;
   logic [DEN_W-1:0]   shift, den_abs;
   logic               ge;

   always_comb begin
      num_mag = div_req.num[NUM_W-1] ? QUO_W'(-div_req.num) : div_req.num[QUO_W-1:0];
      den_abs = div_req.den[DEN_W-1] ? DEN_W'(-div_req.den) : div_req.den;
      shift   = {rem_ff, quo_ff[QUO_W-1]};
      ge      = (shift >= {1'b0, den_ff});
      rem_in  = ge ? (DEN_W-1)'(shift - {1'b0, den_ff}) : shift[DEN_W-2:0];
      quo_in  = {quo_ff[QUO_W-2:0], ge};
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= num_mag;
         rem_ff <= '0;
         den_ff <= den_abs[DEN_W-2:0];
         neg_ff <= div_req.num[NUM_W-1] ^ div_req.den[DEN_W-1];
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

/* rtl/core/msl_back.sv */
module msl_back import msl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_push,
   output rsp_type     rsp,
   input  logic        rsp_full,
   output div_req_type div_req,
   input  div_rsp_type div_rsp
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_TICK = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [SLOT_W-1:0]         idx_ff, sidx_ff, sidx;
   op_type                    op_ff;
   logic                      start_ff;
   logic signed [MULA_W-1:0]  mul_a_ff;
   logic signed [DEN_W-1:0]   mul_b_ff, den_ff;
   logic signed [NUM_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]  prod_full;
   rsp_type                   read_ff;

   logic                      attached_ff [NUM_SLOTS];
   logic signed [15:0]        target_ff   [NUM_SLOTS];
   logic signed [15:0]        sent_ff     [NUM_SLOTS];
   logic [14:0]               step_ff     [NUM_SLOTS];
   logic [11:0]               min_ff      [NUM_SLOTS];
   logic [11:0]               max_ff      [NUM_SLOTS];

   logic signed [16:0]        diff, mag;
   logic signed [15:0]        tick_pulse, map_target, sat_angle;
   logic                      tick_att, above, tick_go, last_slot;
   logic signed [DEN_W-1:0]   span;
   logic [7:0]                deg;
   logic                      is_deg;
   logic [19:0]               deg_abs;
   logic [36:0]               recip_prod;
   logic [12:0]               deg_quot;
   logic signed [13:0]        deg_sq;

   assign sidx     = SLOT_W'(cmd.slot);
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;
   assign prod_full = mul_a_ff * mul_b_ff;
   assign last_slot = (idx_ff == SLOT_W'(NUM_SLOTS - 1));

   assign div_req.start = start_ff;
   assign div_req.num   = prod_ff;
   assign div_req.den   = den_ff;

   always_comb begin
      span   = $signed({1'b0, max_ff[sidx]}) - $signed({1'b0, min_ff[sidx]});
      is_deg = $signed({cmd.value[15], cmd.value}) < $signed({5'd0, cfg.base_min});
      if (cmd.value[15]) begin
         deg = 8'd0;
      end else if (cmd.value > 16'(DEG_SPAN)) begin
         deg = 8'(DEG_SPAN);
      end else begin
         deg = cmd.value[7:0];
      end

      tick_att = attached_ff[idx_ff];
      diff = $signed({target_ff[idx_ff][15], target_ff[idx_ff]})
           - $signed({sent_ff[idx_ff][15], sent_ff[idx_ff]});
      mag  = diff[16] ? -diff : diff;
      if ($signed({2'b00, step_ff[idx_ff]}) < mag) begin
         tick_pulse = diff[16] ? 16'(sent_ff[idx_ff] - $signed({1'b0, step_ff[idx_ff]}))
                               : 16'(sent_ff[idx_ff] + $signed({1'b0, step_ff[idx_ff]}));
      end else begin
         tick_pulse = target_ff[idx_ff];
      end
      above = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (attached_ff[i] && (SLOT_W'(i) > idx_ff)) begin
            above = 1'b1;
         end
      end
      tick_go = !tick_att || !rsp_full;

      // degrees to pulse: product over 180, truncated toward zero
      deg_abs    = prod_ff[NUM_W-1] ? 20'(-prod_ff) : prod_ff[19:0];
      recip_prod = deg_abs[19:2] * DEG_RECIP;
      deg_quot   = recip_prod[RECIP_SHIFT +: 13];
      deg_sq     = prod_ff[NUM_W-1] ? -$signed({1'b0, deg_quot}) : $signed({1'b0, deg_quot});
      map_target = 16'(deg_sq + $signed({4'd0, min_ff[sidx_ff]}));
      if (div_rsp.quot > $signed(NUM_W'(32767))) begin
         sat_angle = 16'sd32767;
      end else if (div_rsp.quot < -$signed(NUM_W'(32768))) begin
         sat_angle = -16'sd32768;
      end else begin
         sat_angle = div_rsp.quot[15:0];
      end

      rsp_push = 1'b0;
      rsp      = read_ff;
      case (state_ff)
         ST_TICK: begin
            rsp_push        = tick_att && !rsp_full;
            rsp.kind        = KIND_PULSE;
            rsp.out_slot    = 3'(idx_ff);
            rsp.pulse_us    = tick_pulse;
            rsp.angle_deg   = '0;
            rsp.is_attached = 1'b1;
            rsp.last        = !above;
         end
         ST_EMIT: rsp_push = !rsp_full;
         default: rsp_push = 1'b0;
      endcase

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  OP_TICK: state_in = ST_TICK;
                  OP_WRITE: state_in = is_deg ? ST_MUL : ST_IDLE;
                  OP_READ: state_in = (span == '0) ? ST_EMIT : ST_MUL;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            if (tick_go && last_slot) begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (op_ff == OP_WRITE) begin
               state_in = ST_IDLE;
            end else if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
         idx_ff   <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            attached_ff[i] <= 1'b0;
            target_ff[i]   <= $signed({4'd0, DEFAULT_RESET});
            sent_ff[i]     <= $signed({4'd0, DEFAULT_RESET});
            step_ff[i]     <= 15'(STEP_RESET);
            min_ff[i]      <= BASE_MIN_RESET;
            max_ff[i]      <= BASE_MAX_RESET;
         end
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == ST_MUL) && (op_ff == OP_READ);
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  op_ff   <= cmd.op;
                  sidx_ff <= sidx;
                  idx_ff  <= '0;
                  case (cmd.op)
                     OP_WRITE: begin
                        if (is_deg) begin
                           mul_a_ff <= $signed({9'd0, deg});
                           mul_b_ff <= span;
                        end else begin
                           target_ff[sidx] <= cmd.value;
                        end
                     end
                     OP_STEP: step_ff[sidx] <= cmd.step_size;
                     OP_ATTACH: begin
                        min_ff[sidx]      <= quantize(cfg.base_min, cmd.min_us);
                        max_ff[sidx]      <= quantize(cfg.base_max, cmd.max_us);
                        attached_ff[sidx] <= 1'b1;
                     end
                     OP_DETACH: begin
                        attached_ff[sidx] <= 1'b0;
                        target_ff[sidx]   <= $signed({4'd0, cfg.default_pulse});
                        sent_ff[sidx]     <= $signed({4'd0, cfg.default_pulse});
                        step_ff[sidx]     <= 15'(STEP_RESET);
                     end
                     OP_READ: begin
                        mul_a_ff <= $signed({target_ff[sidx][15], target_ff[sidx]}) + 17'sd1
                                  - $signed({5'd0, min_ff[sidx]});
                        mul_b_ff <= DEN_W'(DEG_SPAN);
                        den_ff   <= span;
                        read_ff.kind        <= KIND_READ;
                        read_ff.out_slot    <= cmd.slot;
                        read_ff.pulse_us    <= target_ff[sidx];
                        read_ff.angle_deg   <= '0;
                        read_ff.is_attached <= attached_ff[sidx];
                        read_ff.last        <= 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            ST_TICK: begin
               if (tick_go) begin
                  if (tick_att) begin
                     sent_ff[idx_ff] <= tick_pulse;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_MUL: prod_ff <= prod_full[NUM_W-1:0];
            ST_DIV: begin
               if (op_ff == OP_WRITE) begin
                  target_ff[sidx_ff] <= map_target;
               end else if (div_rsp.done) begin
                  read_ff.angle_deg <= sat_angle;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

/* rtl/core/multi_channel_servo_slew_limiter.sv */
// Servo slot table with per-slot ramp limiting. Commands enter through a
// two-beat queue and are carried out one at a time. Set step, attach and
// detach are done on decode, as is a target written in microseconds. A
// target written in degrees goes through decode, a multiply step and a
// reciprocal scaling step. A read goes through a multiply step and a
// radix-2 divider that retires one quotient bit per cycle before the reply
// beat; a read of a slot with zero span skips both. A tick walks all 8
// slots one per cycle and emits a pulse beat for each attached slot, the
// final one marked last; it stalls while the two-beat result queue is
// full. Configuration writes are always ready.
module multi_channel_servo_slew_limiter import msl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [2:0]         req_operation,
   input  logic [2:0]         req_slot,
   input  logic signed [15:0] req_value,
   input  logic [14:0]        req_step_size,
   input  logic [11:0]        req_min_us,
   input  logic [11:0]        req_max_us,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_kind,
   output logic [2:0]         rsp_out_slot,
   output logic signed [15:0] rsp_pulse_us,
   output logic signed [15:0] rsp_angle_deg,
   output logic               rsp_is_attached,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_data
);

   cfg_type     cfg_ff;
   logic        cmd_valid, cmd_pop, rsp_push, rsp_full;
   cmd_type     cmd;
   rsp_type     rsp_in, rsp_out;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_min      <= BASE_MIN_RESET;
         cfg_ff.base_max      <= BASE_MAX_RESET;
         cfg_ff.default_pulse <= DEFAULT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_MIN: cfg_ff.base_min      <= csr_data;
            CSR_BASE_MAX: cfg_ff.base_max      <= csr_data;
            CSR_DEFAULT:  cfg_ff.default_pulse <= csr_data;
            default: ;
         endcase
      end
   end

   msl_cmd_queue u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_operation (req_operation),
      .req_slot      (req_slot),
      .req_value     (req_value),
      .req_step_size (req_step_size),
      .req_min_us    (req_min_us),
      .req_max_us    (req_max_us),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   msl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   msl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in),
      .rsp_full  (rsp_full),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   msl_rsp_queue u_rsp (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_in   (rsp_in),
      .rsp_full (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_out  (rsp_out)
   );

   assign rsp_kind        = rsp_out.kind;
   assign rsp_out_slot    = rsp_out.out_slot;
   assign rsp_pulse_us    = rsp_out.pulse_us;
   assign rsp_angle_deg   = rsp_out.angle_deg;
   assign rsp_is_attached = rsp_out.is_attached;
   assign rsp_last        = rsp_out.last;

   // pulse beats carry no angle and always come from attached slots
   a_pulse_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == KIND_PULSE) |-> (rsp_angle_deg == '0 && rsp_is_attached))
      else $error("pulse beat with angle or detached slot");

   a_read_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == KIND_READ) |-> rsp_last)
      else $error("read reply not marked last");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> (!full && empty))
      else $error("queues not cleared by reset");

endmodule

/* tb/sv/multi_channel_servo_slew_limiter_tb.sv */
`timescale 1ns / 1ps

module multi_channel_servo_slew_limiter_tb;
   import msl_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 60;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   logic [2:0]         req_operation;
   logic [2:0]         req_slot;
   logic signed [15:0] req_value;
   logic [14:0]        req_step_size;
   logic [11:0]        req_min_us;
   logic [11:0]        req_max_us;
   logic               empty;
   logic               pop;
   logic               rsp_kind;
   logic [2:0]         rsp_out_slot;
   logic signed [15:0] rsp_pulse_us;
   logic signed [15:0] rsp_angle_deg;
   logic               rsp_is_attached;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [11:0]        csr_data;

   multi_channel_servo_slew_limiter DUT (.*);

   // predictor copy of the slot table and registers
   int base_min, base_max, default_pulse;
   bit attached [NUM_SLOTS];
   int target [NUM_SLOTS];
   int sent [NUM_SLOTS];
   int step [NUM_SLOTS];
   int lim_lo [NUM_SLOTS];
   int lim_hi [NUM_SLOTS];

   rsp_type pending_beats [$];
   int errors = 0;
   int cycle_count = 0;
   int burst_left = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("multi_channel_servo_slew_limiter_tb failed");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      case (cycle_count[8:7])
         2'd0: pop <= 1'b1;
         2'd1: pop <= 1'($urandom_range(0, 1));
         2'd2: pop <= ($urandom_range(0, 4) == 0);
         default: pop <= (cycle_count[2:0] != 3'd0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type exp_beat;
      if (!reset && pop && !empty) begin
         if (pending_beats.size() == 0) begin
            $display("%0t unexpected beat slot %0d pulse %0d", $time, rsp_out_slot,
                     rsp_pulse_us);
            errors++;
         end else begin
            exp_beat = pending_beats.pop_front();
            if (rsp_kind !== exp_beat.kind) begin
               $display("%0t kind exp %0d got %0d", $time, exp_beat.kind, rsp_kind);
               errors++;
            end
            if (rsp_out_slot !== exp_beat.out_slot) begin
               $display("%0t slot exp %0d got %0d", $time, exp_beat.out_slot, rsp_out_slot);
               errors++;
            end
            if (rsp_pulse_us !== exp_beat.pulse_us) begin
               $display("%0t pulse exp %0d got %0d", $time, exp_beat.pulse_us, rsp_pulse_us);
               errors++;
            end
            if (rsp_angle_deg !== exp_beat.angle_deg) begin
               $display("%0t angle exp %0d got %0d", $time, exp_beat.angle_deg,
                        rsp_angle_deg);
               errors++;
            end
            if (rsp_is_attached !== exp_beat.is_attached) begin
               $display("%0t attached exp %0d got %0d", $time, exp_beat.is_attached,
                        rsp_is_attached);
               errors++;
            end
            if (rsp_last !== exp_beat.last) begin
               $display("%0t last exp %0d got %0d", $time, exp_beat.last, rsp_last);
               errors++;
            end
         end
      end
   end

   function automatic int snap_limit(int base, int req);
      int q;
      q = (base - req) / LIMIT_QUANT;
      return base - q * LIMIT_QUANT;
   endfunction

   task automatic reset_table();
      base_min = BASE_MIN_RESET;
      base_max = BASE_MAX_RESET;
      default_pulse = DEFAULT_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         attached[i] = 0;
         target[i] = default_pulse;
         sent[i] = default_pulse;
         step[i] = STEP_RESET;
         lim_lo[i] = base_min;
         lim_hi[i] = base_max;
      end
   endtask

   task automatic predict_slot_table(input cmd_type c);
      int s, v, diff, mag, t, ang, n;
      rsp_type b;
      s = c.slot;
      n = 0;
      case (c.op)
         OP_WRITE: begin
            t = c.value;
            if (t < base_min) begin
               v = (t < 0) ? 0 : ((t > DEG_SPAN) ? DEG_SPAN : t);
               t = (v * (lim_hi[s] - lim_lo[s])) / DEG_SPAN + lim_lo[s];
            end
            target[s] = t;
         end
         OP_STEP: step[s] = c.step_size;
         OP_ATTACH: begin
            lim_lo[s] = snap_limit(base_min, c.min_us);
            lim_hi[s] = snap_limit(base_max, c.max_us);
            attached[s] = 1;
         end
         OP_DETACH: begin
            attached[s] = 0;
            target[s] = default_pulse;
            sent[s] = default_pulse;
            step[s] = STEP_RESET;
         end
         OP_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (attached[i]) begin
                  t = target[i];
                  diff = t - sent[i];
                  mag = (diff < 0) ? -diff : diff;
                  if (step[i] < mag) t = sent[i] + ((diff < 0) ? -step[i] : step[i]);
                  sent[i] = t;
                  b = '{kind: KIND_PULSE, out_slot: i[2:0], pulse_us: t[15:0],
                        angle_deg: '0, is_attached: 1'b1, last: 1'b0};
                  pending_beats.push_back(b);
                  n++;
               end
            end
            if (n > 0) pending_beats[pending_beats.size() - 1].last = 1'b1;
         end
         OP_READ: begin
            ang = 0;
            if (lim_hi[s] != lim_lo[s]) begin
               ang = ((target[s] + 1 - lim_lo[s]) * DEG_SPAN) / (lim_hi[s] - lim_lo[s]);
               if (ang > 32767) ang = 32767;
               if (ang < -32768) ang = -32768;
            end
            t = target[s];
            b = '{kind: KIND_READ, out_slot: c.slot, pulse_us: t[15:0],
                  angle_deg: ang[15:0], is_attached: attached[s], last: 1'b1};
            pending_beats.push_back(b);
         end
         default: ;
      endcase
   endtask

   task automatic send_cmd(input cmd_type c);
      int gap;
      push <= 1'b1;
      req_operation <= c.op;
      req_slot <= c.slot;
      req_value <= c.value;
      req_step_size <= c.step_size;
      req_min_us <= c.min_us;
      req_max_us <= c.max_us;
      @(negedge clock);
      while (full) @(negedge clock);
      @(posedge clock);
      predict_slot_table(c);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_op(input logic [2:0] op, input int slot, input int value,
                          input int step_size, input int min_us, input int max_us);
      cmd_type c;
      c.op = op_type'(op);
      c.slot = slot[2:0];
      c.value = value[15:0];
      c.step_size = step_size[14:0];
      c.min_us = min_us[11:0];
      c.max_us = max_us[11:0];
      send_cmd(c);
   endtask

   task automatic drain_and_wait();
      push <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input int data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data[11:0];
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         CSR_BASE_MIN: base_min = data[11:0];
         CSR_BASE_MAX: base_max = data[11:0];
         CSR_DEFAULT:  default_pulse = data[11:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_bases(input int bmin, input int bmax, input int dflt);
      drain_and_wait();
      write_csr(CSR_BASE_MIN, bmin);
      write_csr(CSR_BASE_MAX, bmax);
      write_csr(CSR_DEFAULT, dflt);
   endtask

   task automatic test_reset_state();
      for (int i = 0; i < NUM_SLOTS; i++) send_op(OP_READ, i, 0, 0, 0, 0);
      send_op(OP_TICK, 0, 0, 0, 0, 0);
      send_op(OP_SPARE_A, 2, 100, 5, 1, 1);
      send_op(OP_SPARE_B, 7, -1, 32767, 4095, 4095);
   endtask

   task automatic test_ramp_and_degrees();
      send_op(OP_ATTACH, 0, 0, 0, 0, 4095);
      send_op(OP_ATTACH, 7, 0, 0, 4095, 0);
      send_op(OP_ATTACH, 3, 0, 0, 1000, 1000);
      send_op(OP_STEP, 0, 0, 32767, 0, 0);
      send_op(OP_STEP, 7, 0, 0, 0, 0);
      send_op(OP_WRITE, 0, 32767, 0, 0, 0);
      send_op(OP_WRITE, 7, -32768, 0, 0, 0);
      send_op(OP_WRITE, 3, 180, 0, 0, 0);
      send_op(OP_TICK, 0, 0, 0, 0, 0);
      send_op(OP_READ, 0, 0, 0, 0, 0);
      send_op(OP_READ, 3, 0, 0, 0, 0);
      send_op(OP_READ, 7, 0, 0, 0, 0);
      send_op(OP_WRITE, 3, 200, 0, 0, 0);
      send_op(OP_DETACH, 7, 0, 0, 0, 0);
      send_op(OP_READ, 7, 0, 0, 0, 0);
      send_op(OP_TICK, 0, 0, 0, 0, 0);
   endtask

   // angle saturation needs a narrow span and a far target, both directions
   task automatic test_angle_saturation();
      send_op(OP_ATTACH, 5, 0, 0, base_min, base_max - 4);
      send_op(OP_ATTACH, 6, 0, 0, base_min - 4, base_max);
      send_op(OP_WRITE, 5, 32767, 0, 0, 0);
      send_op(OP_WRITE, 6, 32767, 0, 0, 0);
      send_op(OP_READ, 5, 0, 0, 0, 0);
      send_op(OP_READ, 6, 0, 0, 0, 0);
      send_op(OP_DETACH, 5, 0, 0, 0, 0);
      send_op(OP_DETACH, 6, 0, 0, 0, 0);
   endtask

   task automatic test_random(input int count);
      int pick, v;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 2))
            0: v = $urandom_range(0, 200);
            1: v = $urandom_range(400, 2600);
            default: v = $signed(16'($urandom()));
         endcase
         if (pick < 22) send_op(OP_WRITE, $urandom_range(0, 7), v, 0, 0, 0);
         else if (pick < 34)
            send_op(OP_STEP, $urandom_range(0, 7), 0,
                    ($urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 32767)),
                    0, 0);
         else if (pick < 48)
            send_op(OP_ATTACH, $urandom_range(0, 7), 0, 0, $urandom_range(0, 4095),
                    $urandom_range(0, 4095));
         else if (pick < 55) send_op(OP_DETACH, $urandom_range(0, 7), 0, 0, 0, 0);
         else if (pick < 80) send_op(OP_TICK, $urandom_range(0, 7), v, 0, 0, 0);
         else if (pick < 96) send_op(OP_READ, $urandom_range(0, 7), 0, 0, 0, 0);
         else send_op($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                      $urandom_range(0, 7), v, $urandom(), $urandom(), $urandom());
      end
   endtask

   initial begin
      reset_table();
      reset <= 1'b1;
      push <= 1'b0;
      req_operation <= OP_WRITE;
      req_slot <= '0;
      req_value <= '0;
      req_step_size <= '0;
      req_min_us <= '0;
      req_max_us <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_BASE_MIN;
      csr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_ramp_and_degrees();
      test_random(19);
      set_bases(4095, 4095, 4095);
      write_csr(CSR_SPARE, 0);
      test_angle_saturation();
      test_random(19);
      set_bases(0, 0, 0);
      test_random(19);
      set_bases($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
      test_random(18);
      drain_and_wait();

      if (errors == 0) begin
         $display("multi_channel_servo_slew_limiter_tb passed");
      end else begin
         $display("multi_channel_servo_slew_limiter_tb failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/msl_pkg.sv
rtl/core/msl_cmd_queue.sv
rtl/core/msl_rsp_queue.sv
rtl/core/msl_div.sv
rtl/core/msl_back.sv
rtl/core/multi_channel_servo_slew_limiter.sv
tb/sv/multi_channel_servo_slew_limiter_tb.sv
